// ===== rtl/rbs_pkg.sv =====
// Shared constants, types and register codes for the ray/box slab entry test.
// No dependencies; every other file but rbs_checker imports this package.
`default_nettype none

package rbs_pkg;

    // Payload widths
    localparam int CW    = 24;   // Q15.8 coordinate
    localparam int PW    = 41;   // one axis product, signed
    localparam int EW    = 44;   // dot products and slab numerators, signed
    localparam int MW    = 44;   // magnitudes and divider remainders
    localparam int QW    = 17;   // quotient bits (Q1.16, below 2.0)
    localparam int TW    = 18;   // signed slab parameter
    localparam int NSTEP = QW;   // one divider stage per quotient bit

    localparam logic signed [TW-1:0] T_LO  = -18'sd1;
    localparam logic signed [TW-1:0] T_ONE = 18'sd65536;
    localparam logic signed [TW-1:0] T_HI  = 18'sd65537;

    // Configuration register indexes
    localparam logic [2:0] CFG_CENTER_X  = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT    = 3'd3;
    localparam logic [2:0] CFG_LENGTH    = 3'd4;
    localparam logic [2:0] CFG_THICKNESS = 3'd5;
    localparam logic [2:0] CFG_HALF      = 3'd6;

    typedef enum logic [1:0] {
        LM_DIV,     // divide magnitude by magnitude
        LM_NEG,     // signs differ: parameter floors to -1 after saturation
        LM_SAT      // quotient beyond range: saturate high
    } lane_mode_t;

    typedef struct packed {
        lane_mode_t      mode;
        logic [MW-1:0]   rem;
        logic [QW-1:0]   q;
    } lane_t;

    typedef struct packed {
        logic            par;     // direction parallel to this slab
        logic            pmiss;   // parallel and outside the slab
        logic [MW-1:0]   den;     // |f|
        lane_t [1:0]     lane;    // entry and exit numerators
    } axis_t;

    typedef struct packed {
        axis_t [2:0] ax;
    } item_t;

    typedef struct packed {
        logic [2:0][CW-1:0] center;
        logic [2:0][47:0]   axis;
        logic [47:0]        half;
    } rbs_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rbs_if.sv =====
// Channel interfaces: ray input, result output, configuration writes.
// Depends on rbs_pkg for field widths.
`default_nettype none

interface rbs_ray_if;
    import rbs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rbs_res_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [16:0] entry_t;
    modport source (output valid, hit, entry_t, input ready);
    modport sink   (input valid, hit, entry_t, output ready);
endinterface

interface rbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rbs_front.sv =====
// Front end: takes ray beats, projects onto the box axes, classifies each slab.
// Depends on rbs_pkg and rbs_if; feeds rbs_fifo.
`default_nettype none

module rbs_front
    import rbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire rbs_cfg_t cfg_q,
    rbs_ray_if.sink       ray,
    output logic          push_valid,
    input  wire logic     push_ready,
    output item_t         push_data
);

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 en;
    logic signed [24:0]   p_reg  [3];
    logic signed [CW-1:0] d_reg  [3];
    logic signed [PW-1:0] pe_reg [3][3];
    logic signed [PW-1:0] pf_reg [3][3];
    logic signed [EW-1:0] e_reg  [3];
    logic signed [EW-1:0] f_reg  [3];
    logic signed [24:0]   p_next [3];
    logic signed [CW-1:0] org    [3];
    logic signed [CW-1:0] dir    [3];

    // Advance unless the last stage is blocked by the queue
    assign en        = !v3_reg || push_ready;
    assign ray.ready = en;
    assign push_valid = v3_reg;

    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign dir[0] = ray.dir_x;
    assign dir[1] = ray.dir_y;
    assign dir[2] = ray.dir_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_next[k] = 25'(org[k]) - 25'($signed(cfg_q.center[k]));
        end
    end

    // Track valid through the three front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= ray.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Offset, products, dot sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p_reg[k] <= p_next[k];
                d_reg[k] <= dir[k];
            end
            for (int a = 0; a < 3; a++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pe_reg[a][k] <= PW'(p_reg[k]) * PW'($signed(cfg_q.axis[a][16*k +: 16]));
                    pf_reg[a][k] <= PW'(d_reg[k]) * PW'($signed(cfg_q.axis[a][16*k +: 16]));
                end
                e_reg[a] <= EW'(pe_reg[a][0]) + EW'(pe_reg[a][1]) + EW'(pe_reg[a][2]);
                f_reg[a] <= EW'(pf_reg[a][0]) + EW'(pf_reg[a][1]) + EW'(pf_reg[a][2]);
            end
        end
    end

    // Classify each slab and form divider operands
    always_comb
    begin
        logic signed [EW-1:0] h;
        logic signed [EW-1:0] n1;
        logic signed [EW-1:0] n2;
        logic                 f_neg;
        push_data = '0;
        for (int a = 0; a < 3; a++)
        begin
            h     = $signed(EW'({cfg_q.half[16*a +: 16], 14'b0}));
            n1    = -e_reg[a] - h;
            n2    = -e_reg[a] + h;
            f_neg = f_reg[a][EW-1];
            push_data.ax[a].par   = (f_reg[a] == '0);
            push_data.ax[a].pmiss = (f_reg[a] == '0) && ((n1 > 0) || (n2 < 0));
            push_data.ax[a].den   = f_neg ? MW'(-f_reg[a]) : MW'(f_reg[a]);
            push_data.ax[a].lane[0].rem  = n1[EW-1] ? MW'(-n1) : MW'(n1);
            push_data.ax[a].lane[1].rem  = n2[EW-1] ? MW'(-n2) : MW'(n2);
            push_data.ax[a].lane[0].mode =
                ((n1 != '0) && (n1[EW-1] != f_neg)) ? LM_NEG : LM_DIV;
            push_data.ax[a].lane[1].mode =
                ((n2 != '0) && (n2[EW-1] != f_neg)) ? LM_NEG : LM_DIV;
            push_data.ax[a].lane[0].q = '0;
            push_data.ax[a].lane[1].q = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rbs_fifo.sv =====
// Two-entry queue that decouples the front end from the divider back end.
// Depends on rbs_pkg for the item type.
`default_nettype none

module rbs_fifo
    import rbs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_data,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_data
);

    item_t      mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/rbs_back.sv =====
// Back end: six restoring divider lanes, one quotient bit per stage, then the
// slab interval narrowing and result register. Depends on rbs_pkg and rbs_if.
`default_nettype none

module rbs_back
    import rbs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  wire item_t pop_data,
    rbs_res_if.source  res
);

    item_t              st_reg  [NSTEP];
    item_t              st_next [NSTEP];
    item_t              st_in   [NSTEP];
    logic [NSTEP-1:0]   vld_reg;
    logic               res_vld_reg;
    logic               hit_reg, hit_next;
    logic [QW-1:0]      entry_reg, entry_next;
    logic               en;

    // One restoring step; the first step also flags out-of-range quotients
    function automatic lane_t div_step(lane_t l, logic [MW-1:0] den, int k);
        lane_t         o;
        logic [MW-1:0] r;
        o = l;
        r = l.rem;
        if (k == 0)
        begin
            if ((l.mode == LM_DIV) && (r >= {den[MW-2:0], 1'b0}))
                o.mode = LM_SAT;
        end
        else
        begin
            r = {r[MW-2:0], 1'b0};
        end
        if (r >= den)
        begin
            o.q[QW-1-k] = 1'b1;
            r = r - den;
        end
        o.rem = r;
        return o;
    endfunction

    function automatic logic signed [TW-1:0] lane_t_val(lane_t l);
        logic signed [TW-1:0] t;
        case (l.mode)
            LM_NEG:  t = T_LO;
            LM_SAT:  t = T_HI;
            LM_DIV:  t = ($signed({1'b0, l.q}) > T_HI) ? T_HI : $signed({1'b0, l.q});
            default: t = T_HI;
        endcase
        return t;
    endfunction

    assign en        = !res_vld_reg || res.ready;
    assign pop_ready = en;

    assign res.valid   = res_vld_reg;
    assign res.hit     = hit_reg;
    assign res.entry_t = entry_reg;

    // Divider stages
    generate
        for (genvar s = 0; s < NSTEP; s++)
        begin : g_stage
            if (s == 0)
            begin : g_first
                assign st_in[s] = pop_data;
            end
            else
            begin : g_rest
                assign st_in[s] = st_reg[s-1];
            end

            always_comb
            begin
                st_next[s] = st_in[s];
                for (int a = 0; a < 3; a++)
                begin
                    for (int j = 0; j < 2; j++)
                    begin
                        st_next[s].ax[a].lane[j] =
                            div_step(st_in[s].ax[a].lane[j], st_in[s].ax[a].den, s);
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    st_reg[s] <= st_next[s];
            end
        end
    endgenerate

    // Narrow [tmin, tmax] over the three slabs
    always_comb
    begin
        logic signed [TW-1:0] tmin, tmax, t1, t2, lo, hi;
        logic                 pm;
        tmin = '0;
        tmax = T_ONE;
        pm   = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            t1 = lane_t_val(st_reg[NSTEP-1].ax[a].lane[0]);
            t2 = lane_t_val(st_reg[NSTEP-1].ax[a].lane[1]);
            lo = (t1 > t2) ? t2 : t1;
            hi = (t1 > t2) ? t1 : t2;
            if (st_reg[NSTEP-1].ax[a].par)
            begin
                pm = pm || st_reg[NSTEP-1].ax[a].pmiss;
            end
            else
            begin
                if (lo > tmin)
                    tmin = lo;
                if (hi < tmax)
                    tmax = hi;
            end
        end
        hit_next   = !pm && !(tmin > tmax);
        entry_next = hit_next ? tmin[QW-1:0] : '0;
    end

    // Advance valid bits and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NSTEP-2:0], pop_valid};
            res_vld_reg <= vld_reg[NSTEP-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg   <= hit_next;
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ray_box_slab_entry.sv =====
// Top level of the ray segment / oriented box slab test: config registers,
// front end, queue, divider back end. Depends on rbs_pkg, rbs_if and submodules.
//
//   channel  modport  beat contents                             handshake
//   ray      sink     origin_x/y/z, dir_x/y/z (Q15.8)           valid/ready
//   res      source   hit, entry_t (Q1.16)                      valid/ready
//   cfg      sink     index (register 0..6), data               valid/ready, ready=1
//
// One ray per cycle while results are taken; a ray passes three front stages,
// one queue slot, seventeen restoring divider stages (one quotient bit each),
// and the result register. Reset clears the config registers, queue pointers
// and pipeline valid bits. A stalled result holds the back end; the two-entry
// queue lets the front keep taking rays until it fills, then ray.ready drops.
`default_nettype none

module ray_box_slab_entry
    import rbs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rbs_ray_if.sink   ray,
    rbs_res_if.source res,
    rbs_cfg_if.sink   cfg
);

    rbs_cfg_t cfg_reg;
    logic     push_valid, push_ready, pop_valid, pop_ready;
    item_t    push_data, pop_data;

    assign cfg.ready = 1'b1;

    // Write configuration registers; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CENTER_X:  cfg_reg.center[0] <= cfg.data[CW-1:0];
                CFG_CENTER_Y:  cfg_reg.center[1] <= cfg.data[CW-1:0];
                CFG_CENTER_Z:  cfg_reg.center[2] <= cfg.data[CW-1:0];
                CFG_HEIGHT:    cfg_reg.axis[0]   <= cfg.data;
                CFG_LENGTH:    cfg_reg.axis[1]   <= cfg.data;
                CFG_THICKNESS: cfg_reg.axis[2]   <= cfg.data;
                CFG_HALF:      cfg_reg.half      <= cfg.data;
                default:       ;
            endcase
        end
    end

    rbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_q      (cfg_reg),
        .ray        (ray),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rbs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rbs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .res       (res)
    );

endmodule

`default_nettype wire

// ===== rtl/rbs_checker.sv =====
// Port-level checks for ray_box_slab_entry, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module rbs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        hit,
    input wire logic [16:0] entry_t,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // Hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(hit) && $stable(entry_t))
        else $error("result beat changed while stalled");

    // A miss carries a zero entry parameter
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> entry_t == 17'd0)
        else $error("miss with nonzero entry_t");

    // Entry parameter never exceeds 1.0
    a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> entry_t <= 17'd65536)
        else $error("entry_t above 1.0");

    // Configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind ray_box_slab_entry rbs_checker u_rbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .hit       (res.hit),
    .entry_t   (res.entry_t),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

`default_nettype wire
